[hw/rtl/hck_pkg.sv]
package hck_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned FRAC_W = 5;
  localparam int unsigned MULT_W = 13;
  localparam int unsigned NUM_W  = 21;
  localparam int unsigned RECIP_W = 20;
  localparam int unsigned RECIP_SHIFT = 32;

  // Hue is given in half degrees; the circle closes at 180 and has six sectors of 30.
  localparam logic [PIX_W-1:0]  HUE_WRAP    = 8'd180;
  localparam logic [PIX_W-1:0]  SECTOR_SPAN = 8'd30;
  localparam logic [FRAC_W-1:0] SPAN_FRAC   = 5'd30;

  // Common denominator 255 * 30, and half of it for round to nearest.
  localparam logic [MULT_W-1:0] FULL_SCALE = 13'd7650;
  localparam logic [NUM_W-1:0]  FULL_NUM   = 21'd7650;
  localparam logic [NUM_W-1:0]  HALF_SCALE = 21'd3825;

  localparam logic [63:0] RECIP_WIDE = (64'd1 << RECIP_SHIFT) / 64'd7650;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  // Latency of the rounding divider.
  localparam int unsigned DIV_LAT = 3;

  typedef enum logic [2:0] {
    REG_HUE_LOW   = 3'd0,
    REG_HUE_HIGH  = 3'd1,
    REG_SAT_LOW   = 3'd2,
    REG_SAT_HIGH  = 3'd3,
    REG_VAL_LOW   = 3'd4,
    REG_VAL_HIGH  = 3'd5,
    REG_SPILL     = 3'd6
  } cfg_index_t;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_t;

  typedef struct packed {
    sector_t           sector;
    logic [FRAC_W-1:0] frac;
  } hue_split_t;

  typedef struct packed {
    logic             keyed;
    sector_t          sector;
    logic [PIX_W-1:0] val;
    logic [PIX_W-1:0] bg_blue;
    logic [PIX_W-1:0] bg_green;
    logic [PIX_W-1:0] bg_red;
  } side_t;

  // Wraps hue into one turn and splits it into sector and position in the sector.
  function automatic hue_split_t hue_split(logic [PIX_W-1:0] h);
    logic [PIX_W-1:0] hw;
    hue_split_t res;
    hw = (h >= HUE_WRAP) ? (h - HUE_WRAP) : h;
    res.sector = SECTOR_0;
    res.frac   = hw[FRAC_W-1:0];
    for (int i = 1; i < 6; i++) begin
      if (hw >= PIX_W'(i * 30)) begin
        res.sector = sector_t'(3'(i));
        res.frac   = FRAC_W'(hw - PIX_W'(i * 30));
      end
    end
    return res;
  endfunction

endpackage

[hw/rtl/hck_scale_div.sv]
module hck_scale_div
  import hck_pkg::*;
(
  input  logic              clk,
  input  logic [PIX_W-1:0]  val,
  input  logic [MULT_W-1:0] mult,
  output logic [PIX_W-1:0]  quo
);

  // Computes round(val * mult / 7650) with ties upward, by reciprocal
  // multiplication and a single correction step.
  logic [NUM_W-1:0]           num_r;
  logic [NUM_W-1:0]           num_b_r;
  logic [PIX_W-1:0]           est_r;
  logic [PIX_W-1:0]           quo_r;
  logic [NUM_W+RECIP_W-1:0]   prod;
  logic [NUM_W-1:0]           rem;

  assign prod = (NUM_W+RECIP_W)'(num_r) * (NUM_W+RECIP_W)'(RECIP);
  assign rem  = num_b_r - NUM_W'(est_r) * FULL_NUM;

  always_ff @(posedge clk) begin
    num_r   <= NUM_W'(val) * NUM_W'(mult) + HALF_SCALE;
    num_b_r <= num_r;
    est_r   <= prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
    quo_r   <= est_r + PIX_W'(rem >= FULL_NUM);
  end

  assign quo = quo_r;

endmodule

[hw/rtl/hsv_chroma_key_pixel.sv]
// Channel  Ports                                   Handshake
// input    start, busy, in_fg_*, in_bg_*           beat taken when start && !busy
// result   out_valid, out_key_hit, out_blue/green/red  one-cycle strobe, no back-pressure
// config   cfg_we, cfg_index, cfg_data             write when cfg_we is high
//
// Every pixel passes six register stages: one for the range compares, spill and hue
// split, one for the saturation products, three in the reciprocal divider, and the
// output register. A new beat is accepted every cycle; busy is always low.
// Reset is synchronous and active low; it clears valid bits and spill, empties ranges.
// The receiver cannot stall, so the pipeline never holds.
module hsv_chroma_key_pixel
  import hck_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [PIX_W-1:0] in_fg_hue,
  input  logic [PIX_W-1:0] in_fg_sat,
  input  logic [PIX_W-1:0] in_fg_val,
  input  logic [PIX_W-1:0] in_bg_blue,
  input  logic [PIX_W-1:0] in_bg_green,
  input  logic [PIX_W-1:0] in_bg_red,
  output logic             out_valid,
  output logic             out_key_hit,
  output logic [PIX_W-1:0] out_blue,
  output logic [PIX_W-1:0] out_green,
  output logic [PIX_W-1:0] out_red,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [PIX_W-1:0] cfg_data
);

  // Configuration registers.
  logic [PIX_W-1:0] hue_low_r, hue_high_r, sat_low_r, sat_high_r, val_low_r, val_high_r;
  logic [6:0]       spill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_low_r  <= HUE_WRAP;
      hue_high_r <= '0;
      sat_low_r  <= '1;
      sat_high_r <= '0;
      val_low_r  <= '1;
      val_high_r <= '0;
      spill_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HUE_LOW:  hue_low_r  <= cfg_data;
        REG_HUE_HIGH: hue_high_r <= cfg_data;
        REG_SAT_LOW:  sat_low_r  <= cfg_data;
        REG_SAT_HIGH: sat_high_r <= cfg_data;
        REG_VAL_LOW:  val_low_r  <= cfg_data;
        REG_VAL_HIGH: val_high_r <= cfg_data;
        REG_SPILL:    spill_r    <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // Stage 1: key decision on the raw foreground, spill reduction, hue split.
  logic             keyed_nxt;
  logic             spill_hit;
  logic [PIX_W-1:0] sat_nxt;
  hue_split_t       split_nxt;

  always_comb begin
    keyed_nxt = (in_fg_hue >= hue_low_r) && (in_fg_hue <= hue_high_r) &&
                (in_fg_sat >= sat_low_r) && (in_fg_sat <= sat_high_r) &&
                (in_fg_val >= val_low_r) && (in_fg_val <= val_high_r);
    spill_hit = (in_fg_hue > hue_low_r) && (in_fg_hue < hue_high_r) &&
                (in_fg_sat > PIX_W'(spill_r));
    sat_nxt   = spill_hit ? (in_fg_sat - PIX_W'(spill_r)) : in_fg_sat;
    split_nxt = hue_split(in_fg_hue);
  end

  logic              s1_valid_r;
  side_t             s1_side_r;
  logic [PIX_W-1:0]  s1_sat_r;
  logic [FRAC_W-1:0] s1_frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s1_side_r.keyed    <= keyed_nxt;
    s1_side_r.sector   <= split_nxt.sector;
    s1_side_r.val      <= in_fg_val;
    s1_side_r.bg_blue  <= in_bg_blue;
    s1_side_r.bg_green <= in_bg_green;
    s1_side_r.bg_red   <= in_bg_red;
    s1_sat_r           <= sat_nxt;
    s1_frac_r          <= split_nxt.frac;
  end

  // Stage 2: the three scale factors 7650 - S*k. With k = 30 this is
  // 30 * (255 - S), so p shares the denominator of q and t.
  logic              s2_valid_r;
  side_t             s2_side_r;
  logic [MULT_W-1:0] mult_p_r, mult_q_r, mult_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s1_side_r;
    mult_p_r  <= FULL_SCALE - MULT_W'(s1_sat_r) * MULT_W'(SECTOR_SPAN);
    mult_q_r  <= FULL_SCALE - MULT_W'(s1_sat_r) * MULT_W'(s1_frac_r);
    mult_t_r  <= FULL_SCALE - MULT_W'(s1_sat_r) * MULT_W'(SPAN_FRAC - s1_frac_r);
  end

  // Stages 3 to 5: rounding dividers, with the side data delayed alongside.
  logic [PIX_W-1:0] quo_p, quo_q, quo_t;

  hck_scale_div u_div_p (.clk(clk), .val(s2_side_r.val), .mult(mult_p_r), .quo(quo_p));
  hck_scale_div u_div_q (.clk(clk), .val(s2_side_r.val), .mult(mult_q_r), .quo(quo_q));
  hck_scale_div u_div_t (.clk(clk), .val(s2_side_r.val), .mult(mult_t_r), .quo(quo_t));

  logic  dly_valid_r [DIV_LAT];
  side_t dly_side_r  [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) begin
        dly_valid_r[i] <= 1'b0;
      end
    end else begin
      dly_valid_r[0] <= s2_valid_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        dly_valid_r[i] <= dly_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    dly_side_r[0] <= s2_side_r;
    for (int i = 1; i < DIV_LAT; i++) begin
      dly_side_r[i] <= dly_side_r[i-1];
    end
  end

  // Stage 6: sector routing and compositing.
  side_t            fin;
  logic [PIX_W-1:0] blue_nxt, green_nxt, red_nxt;

  assign fin = dly_side_r[DIV_LAT-1];

  always_comb begin
    unique case (fin.sector)
      SECTOR_0: begin blue_nxt = quo_p;   green_nxt = quo_t;   red_nxt = fin.val; end
      SECTOR_1: begin blue_nxt = quo_p;   green_nxt = fin.val; red_nxt = quo_q;   end
      SECTOR_2: begin blue_nxt = quo_t;   green_nxt = fin.val; red_nxt = quo_p;   end
      SECTOR_3: begin blue_nxt = fin.val; green_nxt = quo_q;   red_nxt = quo_p;   end
      SECTOR_4: begin blue_nxt = fin.val; green_nxt = quo_p;   red_nxt = quo_t;   end
      default:  begin blue_nxt = quo_q;   green_nxt = quo_p;   red_nxt = fin.val; end
    endcase
    if (fin.keyed) begin
      blue_nxt  = fin.bg_blue;
      green_nxt = fin.bg_green;
      red_nxt   = fin.bg_red;
    end
  end

  logic             out_valid_r;
  logic             key_r;
  logic [PIX_W-1:0] blue_r, green_r, red_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dly_valid_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= fin.keyed;
    blue_r  <= blue_nxt;
    green_r <= green_nxt;
    red_r   <= red_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_key_hit = key_r;
  assign out_blue    = blue_r;
  assign out_green   = green_r;
  assign out_red     = red_r;

endmodule

[dv/hsv_chroma_key_pixel_tb.sv]
module hsv_chroma_key_pixel_tb;
  import hck_pkg::*;

  // The block ignores writes to this index; it is written to prove that.
  localparam logic [2:0] REG_UNUSED = 3'd7;

  localparam int unsigned PHASES     = 7;
  localparam int unsigned PHASE_BEATS = 250;

  // One foreground HSV pixel plus one background BGR pixel: one input beat.
  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    logic [7:0] bg_b;
    logic [7:0] bg_g;
    logic [7:0] bg_r;
  } pix_t;

  // One composited output pixel: one result beat.
  typedef struct packed {
    logic       key;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } comp_t;

  typedef enum logic {ROW_PIXEL, ROW_CFG} row_kind_t;

  // A row of the directed table is either a register write or a pixel, and a pixel
  // row may carry a hand-written expectation.
  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] idx;
    logic [7:0] data;
    pix_t       pix;
    logic       known;
    comp_t      expv;
  } dir_row_t;

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [PIX_W-1:0] in_fg_hue;
  logic [PIX_W-1:0] in_fg_sat;
  logic [PIX_W-1:0] in_fg_val;
  logic [PIX_W-1:0] in_bg_blue;
  logic [PIX_W-1:0] in_bg_green;
  logic [PIX_W-1:0] in_bg_red;
  logic             out_valid;
  logic             out_key_hit;
  logic [PIX_W-1:0] out_blue;
  logic [PIX_W-1:0] out_green;
  logic [PIX_W-1:0] out_red;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [PIX_W-1:0] cfg_data;

  hsv_chroma_key_pixel u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_fg_hue   (in_fg_hue),
    .in_fg_sat   (in_fg_sat),
    .in_fg_val   (in_fg_val),
    .in_bg_blue  (in_bg_blue),
    .in_bg_green (in_bg_green),
    .in_bg_red   (in_bg_red),
    .out_valid   (out_valid),
    .out_key_hit (out_key_hit),
    .out_blue    (out_blue),
    .out_green   (out_green),
    .out_red     (out_red),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // The testbench's own copy of the key ranges and the spill amount. These follow
  // every register write at the edge that performs it.
  logic [7:0] key_hue_lo, key_hue_hi;
  logic [7:0] key_sat_lo, key_sat_hi;
  logic [7:0] key_val_lo, key_val_hi;
  logic [6:0] spill_sub;

  comp_t    composite_q[$];   // Composited pixels still owed by the block, oldest first.
  dir_row_t directed_rows[$];
  int       idle_pct;
  int       err_count;

  always #6 clk = ~clk;

  // Rounded quotient, ties going up, as the block's divider must produce it.
  function automatic int unsigned round_div(int unsigned num, int unsigned den);
    return (num + den / 2) / den;
  endfunction

  // Works out the composited pixel for one beat under the current settings. The
  // key decision and spill use the raw inputs; the colour conversion uses the
  // possibly desaturated pixel, with out-of-turn hues wrapped for conversion only.
  function automatic comp_t predict_composite(pix_t p);
    int unsigned h, s, v, cs, hw, f, lo_c, fall_c, rise_c;
    logic        keyed;
    sector_t     sec;
    comp_t       c;
    h = p.hue;
    s = p.sat;
    v = p.val;
    keyed = (p.hue >= key_hue_lo) && (p.hue <= key_hue_hi) &&
            (p.sat >= key_sat_lo) && (p.sat <= key_sat_hi) &&
            (p.val >= key_val_lo) && (p.val <= key_val_hi);
    cs = s;
    if ((p.hue > key_hue_lo) && (p.hue < key_hue_hi) && (s > spill_sub))
      cs = s - spill_sub;
    hw = (h >= 180) ? h - 180 : h;
    sec = sector_t'(3'(hw / 30));
    f = hw % 30;
    lo_c   = round_div(v * (255 - cs), 255);
    fall_c = round_div(v * (7650 - cs * f), 7650);
    rise_c = round_div(v * (7650 - cs * (30 - f)), 7650);
    c.key = keyed;
    case (sec)
      SECTOR_0: begin
        c.blue = 8'(lo_c);   c.green = 8'(rise_c); c.red = 8'(v);
      end
      SECTOR_1: begin
        c.blue = 8'(lo_c);   c.green = 8'(v);      c.red = 8'(fall_c);
      end
      SECTOR_2: begin
        c.blue = 8'(rise_c); c.green = 8'(v);      c.red = 8'(lo_c);
      end
      SECTOR_3: begin
        c.blue = 8'(v);      c.green = 8'(fall_c); c.red = 8'(lo_c);
      end
      SECTOR_4: begin
        c.blue = 8'(v);      c.green = 8'(lo_c);   c.red = 8'(rise_c);
      end
      default: begin
        c.blue = 8'(fall_c); c.green = 8'(lo_c);   c.red = 8'(v);
      end
    endcase
    if (keyed) begin
      c.blue  = p.bg_b;
      c.green = p.bg_g;
      c.red   = p.bg_r;
    end
    return c;
  endfunction

  // Picks a channel value that favors the configured window and its edges, so that
  // a good share of random pixels is actually keyed or spill-suppressed.
  function automatic logic [7:0] pick_near(logic [7:0] lo, logic [7:0] hi);
    int unsigned r;
    r = $urandom_range(3);
    if (lo > hi)
      return 8'($urandom_range(255));
    case (r)
      0:       return lo;
      1:       return hi;
      default: return 8'($urandom_range(hi, lo));
    endcase
  endfunction

  // Register write: the data goes out at a falling edge, takes effect at the next
  // rising edge, and the write enable drops again at the falling edge after that.
  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      REG_HUE_LOW:  key_hue_lo = data;
      REG_HUE_HIGH: key_hue_hi = data;
      REG_SAT_LOW:  key_sat_lo = data;
      REG_SAT_HIGH: key_sat_hi = data;
      REG_VAL_LOW:  key_val_lo = data;
      REG_VAL_HIGH: key_val_hi = data;
      REG_SPILL:    spill_sub  = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Writes a whole setting, plus a write to the unused index, which must change
  // nothing.
  task automatic apply_setting(input logic [7:0] hl, input logic [7:0] hh,
                               input logic [7:0] sl, input logic [7:0] sh,
                               input logic [7:0] vl, input logic [7:0] vh,
                               input logic [7:0] sp);
    cfg_write(REG_HUE_LOW, hl);
    cfg_write(REG_HUE_HIGH, hh);
    cfg_write(REG_SAT_LOW, sl);
    cfg_write(REG_SAT_HIGH, sh);
    cfg_write(REG_VAL_LOW, vl);
    cfg_write(REG_VAL_HIGH, vh);
    cfg_write(REG_SPILL, sp);
    cfg_write(REG_UNUSED, 8'($urandom_range(255)));
  endtask

  // Sends one beat. The sender may sit idle for a random number of cycles first;
  // start then stays high until the beat is taken. It is only lowered by the next
  // call's idle cycles or by a drain, so it never toggles within one time step.
  task automatic send_pixel(input pix_t p, input logic known, input comp_t expv);
    comp_t e;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start       = 1'b1;
    in_fg_hue   = p.hue;
    in_fg_sat   = p.sat;
    in_fg_val   = p.val;
    in_bg_blue  = p.bg_b;
    in_bg_green = p.bg_g;
    in_bg_red   = p.bg_r;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    e = known ? expv : predict_composite(p);
    composite_q.push_back(e);
  endtask

  // Stops sending and waits until every owed pixel has come back, so that the
  // block is idle before registers change.
  task automatic drain;
    @(negedge clk);
    start = 1'b0;
    while (composite_q.size() != 0)
      @(posedge clk);
  endtask

  task automatic dir_cfg(input logic [2:0] idx, input logic [7:0] data);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_CFG;
    row.idx   = idx;
    row.data  = data;
    directed_rows.push_back(row);
  endtask

  task automatic dir_pix(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                         input logic [7:0] bb, input logic [7:0] bg, input logic [7:0] br);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_PIXEL;
    row.pix  = {h, s, v, bb, bg, br};
    directed_rows.push_back(row);
  endtask

  // Pixel row whose result can be read straight off the conversion rules.
  task automatic dir_known(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
                           input logic [7:0] bb, input logic [7:0] bg, input logic [7:0] br,
                           input logic k, input logic [7:0] eb, input logic [7:0] eg,
                           input logic [7:0] er);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_PIXEL;
    row.pix   = {h, s, v, bb, bg, br};
    row.known = 1'b1;
    row.expv  = {k, eb, eg, er};
    directed_rows.push_back(row);
  endtask

  // Result checker. Every strobed beat must match the oldest owed pixel; a beat with
  // nothing owed is an error too. Outputs are sampled at the rising edge, before the
  // block's own registers update.
  always @(posedge clk) begin
    comp_t got, want;
    if (rst_n && out_valid) begin
      got = {out_key_hit, out_blue, out_green, out_red};
      if (composite_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("ERROR: result beat with nothing expected: key=%0b bgr=%0d,%0d,%0d",
                   got.key, got.blue, got.green, got.red);
      end else begin
        want = composite_q.pop_front();
        if (got.key !== want.key || got.blue !== want.blue ||
            got.green !== want.green || got.red !== want.red) begin
          err_count++;
          if (err_count <= 10)
            $display("ERROR: key=%0b bgr=%0d,%0d,%0d, expected key=%0b bgr=%0d,%0d,%0d",
                     got.key, got.blue, got.green, got.red,
                     want.key, want.blue, want.green, want.red);
        end
      end
    end
  end

  // Watchdog, sized for many times the slowest legal run.
  initial begin
    #(12 * 400000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int         pct_tab[PHASES];
    pix_t       p;
    dir_row_t   row;
    logic [7:0] hl, hh, sl, sh, vl, vh;

    pct_tab     = '{0, 69, 33, 0, 69, 33, 69};
    clk         = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_fg_hue   = '0;
    in_fg_sat   = '0;
    in_fg_val   = '0;
    in_bg_blue  = '0;
    in_bg_green = '0;
    in_bg_red   = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    err_count   = 0;
    idle_pct    = 0;

    // Reset leaves every range empty and spill off.
    key_hue_lo = 8'd180;
    key_hue_hi = 8'd0;
    key_sat_lo = 8'd255;
    key_sat_hi = 8'd0;
    key_val_lo = 8'd255;
    key_val_hi = 8'd0;
    spill_sub  = 7'd0;

    // Directed part, first under the reset setting: nothing is keyed, so the
    // conversion shows through. Black, white and the pure primaries are easy to
    // read off; the rest is left to the predictor.
    dir_known(8'd0,   8'd0,   8'd0,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0, 8'd0, 8'd0);
    dir_known(8'd0,   8'd0,   8'd255, 8'd1,   8'd2,   8'd3,   1'b0, 8'd255, 8'd255, 8'd255);
    dir_known(8'd0,   8'd255, 8'd255, 8'd9,   8'd9,   8'd9,   1'b0, 8'd0, 8'd0, 8'd255);
    dir_known(8'd60,  8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0, 8'd255, 8'd0);
    dir_known(8'd120, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0,   1'b0, 8'd255, 8'd0, 8'd0);
    dir_pix(8'd179, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    dir_pix(8'd29,  8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
    dir_pix(8'd30,  8'd255, 8'd128, 8'd0, 8'd0, 8'd0);
    dir_pix(8'd150, 8'd100, 8'd200, 8'd0, 8'd0, 8'd0);
    // Hues past the end of the turn wrap for conversion.
    dir_pix(8'd180, 8'd128, 8'd77,  8'd0, 8'd0, 8'd0);
    dir_pix(8'd255, 8'd200, 8'd200, 8'd0, 8'd0, 8'd0);

    // A green-screen style window with moderate spill.
    dir_cfg(REG_HUE_LOW,  8'd40);
    dir_cfg(REG_HUE_HIGH, 8'd80);
    dir_cfg(REG_SAT_LOW,  8'd60);
    dir_cfg(REG_SAT_HIGH, 8'd200);
    dir_cfg(REG_VAL_LOW,  8'd50);
    dir_cfg(REG_VAL_HIGH, 8'd250);
    dir_cfg(REG_SPILL,    8'd30);
    // Both window corners are keyed, so the background comes through.
    dir_known(8'd40, 8'd60,  8'd50,  8'd11,  8'd22,  8'd33,  1'b1, 8'd11, 8'd22, 8'd33);
    dir_known(8'd80, 8'd200, 8'd250, 8'hAA,  8'h55,  8'hFF,  1'b1, 8'hAA, 8'h55, 8'hFF);
    // One step outside every limit but the lower value one; spill is strict on hue and needs sat above it.
    dir_pix(8'd39, 8'd100, 8'd100, 8'd1, 8'd2, 8'd3);
    dir_pix(8'd81, 8'd100, 8'd100, 8'd1, 8'd2, 8'd3);
    dir_pix(8'd60, 8'd59,  8'd100, 8'd1, 8'd2, 8'd3);
    dir_pix(8'd60, 8'd201, 8'd251, 8'd1, 8'd2, 8'd3);
    dir_pix(8'd60, 8'd30,  8'd200, 8'd1, 8'd2, 8'd3);
    dir_pix(8'd60, 8'd31,  8'd200, 8'd1, 8'd2, 8'd3);

    // Hue window past the turn, spill written with its top bit set (seven bits
    // survive), and a write to the unused index.
    dir_cfg(REG_HUE_LOW,  8'd0);
    dir_cfg(REG_HUE_HIGH, 8'd255);
    dir_cfg(REG_SPILL,    8'hFF);
    dir_cfg(REG_UNUSED,   8'h5A);
    dir_pix(8'd200, 8'd255, 8'd255, 8'd7, 8'd8, 8'd9);
    dir_pix(8'd100, 8'd127, 8'd255, 8'd7, 8'd8, 8'd9);
    dir_pix(8'd100, 8'd128, 8'd255, 8'd7, 8'd8, 8'd9);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_CFG) begin
        drain();
        cfg_write(row.idx, row.data);
      end else begin
        send_pixel(row.pix, row.known, row.expv);
      end
    end

    // Random part. Each phase first settles the block, then loads a setting: the
    // first three are the extremes (everything keyed, the empty reset window, and
    // a hue window past the turn with the largest spill), the rest are random.
    // Half of the beats aim at the window so keyed and spill paths get real use.
    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: apply_setting(8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0);
        1: apply_setting(8'd180, 8'd0,   8'd255, 8'd0,   8'd255, 8'd0,   8'd0);
        2: apply_setting(8'd0,   8'd180, 8'd0,   8'd255, 8'd0,   8'd255, 8'd127);
        default: begin
          hl = 8'($urandom_range(150));
          hh = 8'($urandom_range(180, hl));
          sl = 8'($urandom_range(200));
          sh = 8'($urandom_range(255, sl));
          vl = 8'($urandom_range(200));
          vh = 8'($urandom_range(255, vl));
          // The last phase also lets the spill data carry junk in its top bit.
          apply_setting(hl, hh, sl, sh, vl, vh,
                        (ph == PHASES - 1) ? 8'($urandom_range(255))
                                           : 8'($urandom_range(100)));
        end
      endcase
      idle_pct = pct_tab[ph];
      repeat (PHASE_BEATS) begin
        if ($urandom_range(1) == 1) begin
          p.hue = pick_near(key_hue_lo, key_hue_hi);
          p.sat = pick_near(key_sat_lo, key_sat_hi);
          p.val = pick_near(key_val_lo, key_val_hi);
        end else begin
          p.hue = 8'($urandom_range(255));
          p.sat = 8'($urandom_range(255));
          p.val = 8'($urandom_range(255));
        end
        p.bg_b = 8'($urandom_range(255));
        p.bg_g = 8'($urandom_range(255));
        p.bg_r = 8'($urandom_range(255));
        send_pixel(p, 1'b0, '0);
      end
    end

    // All beats are in; wait for the last results and then keep the clock running, so
    // that a stray extra beat would still be caught.
    drain();
    repeat (12) @(posedge clk);
    if (err_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

[hsv_chroma_key_pixel.f]
hw/rtl/hck_pkg.sv
hw/rtl/hck_scale_div.sv
hw/rtl/hsv_chroma_key_pixel.sv
dv/hsv_chroma_key_pixel_tb.sv
